>>> hdl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg: shared types and constants for the point-in-polygon test
// Request codes, register map, controller states and the command/status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package pip_pkg;

  localparam int unsigned MAX_VERTICES = 64;
  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned MIN_VERTICES = 3;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned INDEX_W      = 6;
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;

  localparam logic [APB_AW-1:0] REG_VERTEX_COUNT = 3'd0;

  typedef enum logic {
    REQ_WRITE = 1'b0,
    REQ_QUERY = 1'b1
  } req_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_LAST,
    ST_PRIME,
    ST_EDGE,
    ST_MUL,
    ST_DIV,
    ST_CMP,
    ST_NEXT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic load_point;
    logic clear_par;
    logic load_prev;
    logic capture;
    logic mul;
    logic div_step;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic straddle;
    logic div_done;
  } sts_t;

endpackage

>>> hdl/pip_if.sv
// ----------------------------------------------------------------------------
// pip_if: request and result channels
// Valid/ready channels carrying one request and one inside flag.
// ----------------------------------------------------------------------------
interface pip_req_if #(
  parameter int unsigned CoordBits = pip_pkg::COORD_BITS
) ();
  logic                              valid;
  logic                              ready;
  logic                              req_type;
  logic [pip_pkg::INDEX_W-1:0]       vertex_index;
  logic signed [CoordBits-1:0]       coord_x;
  logic signed [CoordBits-1:0]       coord_y;

  modport source (output valid, req_type, vertex_index, coord_x, coord_y, input ready);
  modport sink (input valid, req_type, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pip_res_if ();
  logic valid;
  logic ready;
  logic inside_res;

  modport source (output valid, inside_res, input ready);
  modport sink (input valid, inside_res, output ready);
endinterface

>>> hdl/polygon_point_inside_test.sv
// ----------------------------------------------------------------------------
// polygon_point_inside_test: even-odd point-in-polygon test
// Stores polygon vertices and answers inside/outside queries.
// ----------------------------------------------------------------------------
// A vertex write gives no result. A query walks the first vertex_count table
// entries, capped at MaxVertices, as a closed ring, one edge at a time through
// a vertex memory with one registered read port: setup reads the closing
// vertex and vertex zero, each edge is captured and tested for whether the
// query y straddles it, and a straddling edge then goes through a multiply,
// the bit-serial restoring divider that forms the crossing x and a compare
// before the next vertex is read; the result is then emitted. Fewer than three
// vertices answer outside. A finished result waits in an output register
// while the next request is taken.
module polygon_point_inside_test #(
  parameter int unsigned MaxVertices = pip_pkg::MAX_VERTICES,
  parameter int unsigned CoordBits   = pip_pkg::COORD_BITS
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  pip_req_if.sink                      req_i,
  pip_res_if.source                    res_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pip_pkg::APB_AW-1:0]   paddr,
  input  logic [pip_pkg::APB_DW-1:0]   pwdata,
  output logic [pip_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);

  logic [COUNT_W-1:0] vertex_count_q;
  cmd_t               cmd;
  sts_t               sts;
  logic [AW-1:0]      addr;

  assign pready = 1'b1;
  assign prdata = (paddr == REG_VERTEX_COUNT) ? APB_DW'(vertex_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= '0;
    end else if (psel && penable && pwrite && pready && (paddr == REG_VERTEX_COUNT)) begin
      vertex_count_q <= pwdata[COUNT_W-1:0];
    end
  end

  pip_ctrl #(
    .MaxVertices(MaxVertices)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vertex_count_i(vertex_count_q),
    .req_valid_i   (req_i.valid),
    .req_type_i    (req_i.req_type),
    .vertex_index_i(req_i.vertex_index),
    .req_ready_o   (req_i.ready),
    .res_valid_o   (res_o.valid),
    .res_ready_i   (res_o.ready),
    .cmd_o         (cmd),
    .addr_o        (addr),
    .sts_i         (sts)
  );

  pip_dp #(
    .MaxVertices(MaxVertices),
    .CoordBits  (CoordBits)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .addr_i        (addr),
    .vertex_index_i(req_i.vertex_index),
    .coord_x_i     (req_i.coord_x),
    .coord_y_i     (req_i.coord_y),
    .sts_o         (sts),
    .inside_o      (res_o.inside_res)
  );

endmodule

>>> hdl/pip_ctrl.sv
// ----------------------------------------------------------------------------
// pip_ctrl: query sequencer
// Walks the polygon edges, steps the datapath through multiply, divide and
// compare, and owns the request and result handshakes.
// ----------------------------------------------------------------------------
module pip_ctrl #(
  parameter int unsigned MaxVertices = pip_pkg::MAX_VERTICES
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [pip_pkg::COUNT_W-1:0]          vertex_count_i,
  input  logic                                 req_valid_i,
  input  logic                                 req_type_i,
  input  logic [pip_pkg::INDEX_W-1:0]          vertex_index_i,
  output logic                                 req_ready_o,
  output logic                                 res_valid_o,
  input  logic                                 res_ready_i,
  output pip_pkg::cmd_t                        cmd_o,
  output logic [$clog2(MaxVertices)-1:0]       addr_o,
  input  pip_pkg::sts_t                        sts_i
);
  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CW = $clog2(MaxVertices + 1);

  state_e         state_q, state_d;
  logic [AW-1:0]  idx_q, idx_d;
  logic           res_valid_q, res_valid_d;
  logic [CW-1:0]  n_sat;
  logic [AW-1:0]  last_idx;
  logic           accept;

  assign n_sat    = (int'(vertex_count_i) > int'(MaxVertices)) ? CW'(MaxVertices)
                                                                : CW'(vertex_count_i);
  assign last_idx = AW'(n_sat - CW'(1));
  assign accept   = req_valid_i && req_ready_o;

  assign req_ready_o = (state_q == ST_IDLE);
  assign res_valid_o = res_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      idx_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    res_valid_d = res_valid_q && !res_ready_i;
    cmd_o       = '0;
    addr_o      = '0;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_WRITE) begin
            cmd_o.wr_en = (int'(vertex_index_i) < int'(MaxVertices));
          end else begin
            cmd_o.load_point = 1'b1;
            cmd_o.clear_par  = 1'b1;
            state_d = (int'(n_sat) < int'(MIN_VERTICES)) ? ST_DONE : ST_RD_LAST;
          end
        end
      end
      ST_RD_LAST: begin
        // previous vertex of edge zero closes the ring
        cmd_o.rd_en = 1'b1;
        addr_o      = last_idx;
        state_d     = ST_PRIME;
      end
      ST_PRIME: begin
        cmd_o.load_prev = 1'b1;
        cmd_o.rd_en     = 1'b1;
        addr_o          = '0;
        idx_d           = '0;
        state_d         = ST_EDGE;
      end
      ST_EDGE: begin
        cmd_o.capture = 1'b1;
        state_d = sts_i.straddle ? ST_MUL : ST_NEXT;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_done) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        cmd_o.cmp = 1'b1;
        state_d   = ST_NEXT;
      end
      ST_NEXT: begin
        cmd_o.load_prev = 1'b1;
        if (idx_q == last_idx) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.rd_en = 1'b1;
          addr_o      = idx_q + AW'(1);
          idx_d       = idx_q + AW'(1);
          state_d     = ST_EDGE;
        end
      end
      ST_DONE: begin
        // hold until the result slot is free
        if (!res_valid_q || res_ready_i) begin
          cmd_o.emit  = 1'b1;
          res_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

>>> hdl/pip_dp.sv
// ----------------------------------------------------------------------------
// pip_dp: vertex memory and crossing arithmetic
// Holds the vertex table, the edge operands, a multiplier, a restoring
// divider and the crossing parity.
// ----------------------------------------------------------------------------
module pip_dp #(
  parameter int unsigned MaxVertices = pip_pkg::MAX_VERTICES,
  parameter int unsigned CoordBits   = pip_pkg::COORD_BITS
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  pip_pkg::cmd_t                  cmd_i,
  input  logic [$clog2(MaxVertices)-1:0] addr_i,
  input  logic [pip_pkg::INDEX_W-1:0]    vertex_index_i,
  input  logic signed [CoordBits-1:0]    coord_x_i,
  input  logic signed [CoordBits-1:0]    coord_y_i,
  output pip_pkg::sts_t                  sts_o,
  output logic                           inside_o
);
  import pip_pkg::*;

  localparam int unsigned AW = $clog2(MaxVertices);
  localparam int unsigned CB = CoordBits;
  localparam int unsigned PW = 2 * CoordBits;
  localparam int unsigned SW = $clog2(PW);

  logic signed [CB-1:0] mem_x [MaxVertices];
  logic signed [CB-1:0] mem_y [MaxVertices];

  logic signed [CB-1:0] rd_x_q, rd_y_q;
  logic signed [CB-1:0] prev_x_q, prev_y_q;
  logic signed [CB-1:0] px_q, py_q;
  logic signed [CB-1:0] xi_q;
  logic [CB-1:0]        ma_q, mb_q, den_q;
  logic                 neg_q;
  logic [PW-1:0]        num_q;
  logic [CB-1:0]        rem_q;
  logic [SW-1:0]        cnt_q;
  logic                 par_q;
  logic                 res_q;

  logic signed [CB:0]   dx, dyq, dd;
  logic [CB:0]          adx, adyq, add;
  logic [CB:0]          rem_sh, rem_sub;
  logic                 ge;
  logic signed [CB+1:0] qs;
  logic signed [CB+2:0] cx, px_ext;

  // write port
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      mem_x[AW'(vertex_index_i)] <= coord_x_i;
      mem_y[AW'(vertex_index_i)] <= coord_y_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_x_q <= mem_x[addr_i];
      rd_y_q <= mem_y[addr_i];
    end
  end

  assign sts_o.straddle = ((rd_y_q <= py_q) && (py_q < prev_y_q)) ||
                          ((prev_y_q <= py_q) && (py_q < rd_y_q));
  assign sts_o.div_done = (cnt_q == SW'(PW - 1));

  assign dx   = {prev_x_q[CB-1], prev_x_q} - {rd_x_q[CB-1], rd_x_q};
  assign dyq  = {py_q[CB-1], py_q} - {rd_y_q[CB-1], rd_y_q};
  assign dd   = {prev_y_q[CB-1], prev_y_q} - {rd_y_q[CB-1], rd_y_q};
  assign adx  = dx[CB]  ? -dx  : dx;
  assign adyq = dyq[CB] ? -dyq : dyq;
  assign add  = dd[CB]  ? -dd  : dd;

  assign rem_sh  = {rem_q, num_q[PW-1]};
  assign rem_sub = rem_sh - {1'b0, den_q};
  assign ge      = (rem_sh >= {1'b0, den_q});

  assign qs     = neg_q ? -$signed({2'b00, num_q[CB-1:0]}) : $signed({2'b00, num_q[CB-1:0]});
  assign cx     = $signed({qs[CB+1], qs}) + $signed({{3{xi_q[CB-1]}}, xi_q});
  assign px_ext = $signed({{3{px_q[CB-1]}}, px_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_point) begin
      px_q <= coord_x_i;
      py_q <= coord_y_i;
    end
    if (cmd_i.load_prev) begin
      prev_x_q <= rd_x_q;
      prev_y_q <= rd_y_q;
    end
    if (cmd_i.capture) begin
      ma_q  <= adx[CB-1:0];
      mb_q  <= adyq[CB-1:0];
      den_q <= add[CB-1:0];
      neg_q <= dx[CB] ^ dyq[CB] ^ dd[CB];
      xi_q  <= rd_x_q;
    end
    if (cmd_i.mul) begin
      num_q <= PW'(ma_q * mb_q);
      rem_q <= '0;
      cnt_q <= '0;
    end else if (cmd_i.div_step) begin
      // one quotient bit per step, shifted in where the dividend leaves
      num_q <= {num_q[PW-2:0], ge};
      rem_q <= ge ? rem_sub[CB-1:0] : rem_sh[CB-1:0];
      cnt_q <= cnt_q + SW'(1);
    end
    if (cmd_i.emit) begin
      res_q <= par_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      par_q <= 1'b0;
    end else if (cmd_i.clear_par) begin
      par_q <= 1'b0;
    end else if (cmd_i.cmp && (px_ext < cx)) begin
      par_q <= ~par_q;
    end
  end

  assign inside_o = res_q;

endmodule

>>> hdl/pip_checker.sv
// ----------------------------------------------------------------------------
// pip_checker: port-level checks for the point-in-polygon test
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module pip_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_i,
  input logic req_type_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic inside_res_i
);
  import pip_pkg::*;

  // in the cycle after a query is taken, the block is not ready for a request
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_type_i == REQ_QUERY) |=> !req_ready_i)
    else $error("request taken right after a query");

  // a vertex write never produces a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_i && req_type_i == REQ_WRITE) |=> !$rose(res_valid_i))
    else $error("result appeared after a vertex write");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> res_valid_i)
    else $error("result dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_i && !res_ready_i) |=> $stable(inside_res_i))
    else $error("result changed while stalled");

endmodule

bind polygon_point_inside_test pip_checker u_pip_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .req_valid_i (req_i.valid),
  .req_ready_i (req_i.ready),
  .req_type_i  (req_i.req_type),
  .res_valid_i (res_o.valid),
  .res_ready_i (res_o.ready),
  .inside_res_i(res_o.inside_res)
);
